// ===== rtl/permutation_cycle_decomposer_macros.svh =====
// Assertion macros for the permutation cycle decomposer
`ifndef PERMUTATION_CYCLE_DECOMPOSER_MACROS_SVH
`define PERMUTATION_CYCLE_DECOMPOSER_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pcd assertion failed");
// checked at every edge, reset included
`define PCD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pcd assertion failed");
`else
`define PCD_ASSERT(lbl, prop)
`define PCD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/pcd_pkg.sv =====
// Shared types, sizes and helpers of the permutation cycle decomposer
package pcd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int PT_W       = 7;
  localparam int CYC_W      = 6;

  typedef logic [PT_W-1:0]   point_t;
  typedef logic [CYC_W-1:0]  cyc_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // size register as the run sees it: zero acts as one, clipped to the store depth
  function automatic point_t eff_size(input point_t s);
    point_t r;
    if (s == '0) begin
      r = PT_W'(1);
    end else if (s > PT_W'(MAX_POINTS)) begin
      r = PT_W'(MAX_POINTS);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/permutation_cycle_decomposer.sv =====
// Permutation cycle decomposer: image loader, range check and cycle walker
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_valid/in_stall  | in_image
//  out_    | out | out_valid/out_stall| element, cycle_idx, cycle_end, last, error
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_perm_size
//
// Each image beat is taken while loading. The beat that closes a run starts a range
// check, one image store read and one evaluation per point, then a decide step.
// The walk does a store read and an evaluation per emitted point, plus a scan step per
// start position looked at (at most n). The input is held off from the closing beat
// until the run's last result or its error is issued, and out_stall can hold it off longer.
// Synchronous active-low reset. The final result may wait while the next run loads.
`include "permutation_cycle_decomposer_macros.svh"

module permutation_cycle_decomposer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pcd_pkg::point_t in_image,
  output logic            out_valid,
  input  logic            out_stall,
  output pcd_pkg::point_t out_element,
  output pcd_pkg::cyc_t   out_cycle_idx,
  output logic            out_cycle_end,
  output logic            out_last,
  output logic            out_error,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  pcd_pkg::point_t cfg_perm_size
);
  import pcd_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_CHK_DONE,
    ST_SCAN,
    ST_WALK_RD,
    ST_WALK_EV
  } state_t;

  state_t                state_r, state_nxt;
  point_t                perm_size_r, perm_size_nxt;
  point_t                load_cnt_r, load_cnt_nxt;
  logic                  range_err_r, range_err_nxt;
  point_t                ptr_r, ptr_nxt;
  addr_t                 cur_r, cur_nxt;
  cyc_t                  cyc_r, cyc_nxt;
  point_t                emit_cnt_r, emit_cnt_nxt;
  logic [MAX_POINTS-1:0] visited_r, visited_nxt;

  logic                  out_valid_r, out_valid_nxt;
  point_t                out_element_r, out_element_nxt;
  cyc_t                  out_cyc_r, out_cyc_nxt;
  logic                  out_cend_r, out_cend_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_err_r, out_err_nxt;

  // image store
  point_t                mem [MAX_POINTS];
  point_t                mem_q_r;
  logic                  mem_we;
  addr_t                 mem_waddr;
  addr_t                 mem_raddr;

  point_t                n;
  point_t                cnt_inc;
  logic                  out_free;
  addr_t                 nxt_pt;
  logic                  hit;
  logic                  is_last;

  assign n         = eff_size(perm_size_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_inc   = load_cnt_r + PT_W'(1);
  assign nxt_pt    = ADDR_W'(mem_q_r - PT_W'(1));
  assign hit       = visited_r[nxt_pt];
  assign is_last   = (emit_cnt_r == (n - PT_W'(1)));
  assign mem_waddr = load_cnt_r[ADDR_W-1:0];
  assign mem_raddr = (state_r == ST_CHK_RD) ? ptr_r[ADDR_W-1:0] : cur_r;

  assign in_stall         = (state_r != ST_LOAD);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_element      = out_element_r;
  assign out_cycle_idx    = out_cyc_r;
  assign out_cycle_end    = out_cend_r;
  assign out_last         = out_last_r;
  assign out_error        = out_err_r;

  always_comb begin
    state_nxt       = state_r;
    perm_size_nxt   = perm_size_r;
    load_cnt_nxt    = load_cnt_r;
    range_err_nxt   = range_err_r;
    ptr_nxt         = ptr_r;
    cur_nxt         = cur_r;
    cyc_nxt         = cyc_r;
    emit_cnt_nxt    = emit_cnt_r;
    visited_nxt     = visited_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_element_nxt = out_element_r;
    out_cyc_nxt     = out_cyc_r;
    out_cend_nxt    = out_cend_r;
    out_last_nxt    = out_last_r;
    out_err_nxt     = out_err_r;
    mem_we          = 1'b0;

    if (cfg_valid) begin
      perm_size_nxt = cfg_perm_size;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (in_image == '0 || in_image > n) begin
            range_err_nxt = 1'b1;
          end
          mem_we = (load_cnt_r < PT_W'(MAX_POINTS));
          if (cnt_inc >= n) begin
            load_cnt_nxt = '0;
            ptr_nxt      = '0;
            visited_nxt  = '0;
            state_nxt    = ST_CHK_RD;
          end else begin
            load_cnt_nxt = cnt_inc;
          end
        end
      end
      ST_CHK_RD: begin
        state_nxt = ST_CHK_EV;
      end
      ST_CHK_EV: begin
        if (mem_q_r == '0 || mem_q_r > n) begin
          range_err_nxt = 1'b1;
        end
        if (ptr_r + PT_W'(1) >= n) begin
          ptr_nxt   = '0;
          state_nxt = ST_CHK_DONE;
        end else begin
          ptr_nxt   = ptr_r + PT_W'(1);
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_DONE: begin
        if (range_err_r) begin
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_element_nxt = '0;
            out_cyc_nxt     = '0;
            out_cend_nxt    = 1'b0;
            out_last_nxt    = 1'b1;
            out_err_nxt     = 1'b1;
            range_err_nxt   = 1'b0;
            state_nxt       = ST_LOAD;
          end
        end else begin
          cyc_nxt      = '0;
          emit_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one visited point skipped per cycle
        if (visited_r[ptr_r[ADDR_W-1:0]]) begin
          ptr_nxt = ptr_r + PT_W'(1);
        end else begin
          visited_nxt[ptr_r[ADDR_W-1:0]] = 1'b1;
          cur_nxt   = ptr_r[ADDR_W-1:0];
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = PT_W'(cur_r) + PT_W'(1);
          out_cyc_nxt     = cyc_r;
          out_cend_nxt    = hit;
          out_last_nxt    = is_last;
          out_err_nxt     = 1'b0;
          emit_cnt_nxt    = emit_cnt_r + PT_W'(1);
          if (is_last) begin
            ptr_nxt     = '0;
            visited_nxt = '0;
            state_nxt   = ST_LOAD;
          end else if (hit) begin
            cyc_nxt   = cyc_r + CYC_W'(1);
            ptr_nxt   = ptr_r + PT_W'(1);
            state_nxt = ST_SCAN;
          end else begin
            visited_nxt[nxt_pt] = 1'b1;
            cur_nxt   = nxt_pt;
            state_nxt = ST_WALK_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      perm_size_r <= PT_W'(MAX_POINTS);
      load_cnt_r  <= '0;
      range_err_r <= 1'b0;
      ptr_r       <= '0;
      cur_r       <= '0;
      cyc_r       <= '0;
      emit_cnt_r  <= '0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      perm_size_r <= perm_size_nxt;
      load_cnt_r  <= load_cnt_nxt;
      range_err_r <= range_err_nxt;
      ptr_r       <= ptr_nxt;
      cur_r       <= cur_nxt;
      cyc_r       <= cyc_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_element_r <= out_element_nxt;
    out_cyc_r     <= out_cyc_nxt;
    out_cend_r    <= out_cend_nxt;
    out_last_r    <= out_last_nxt;
    out_err_r     <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_image;
    end
    mem_q_r <= mem[mem_raddr];
  end

  `PCD_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid)
  `PCD_ASSERT(a_err_is_last, out_valid && out_error |-> out_last && out_element == '0)
  `PCD_ASSERT(a_last_closes, out_valid && out_last && !out_error |-> out_cycle_end)
  `PCD_ASSERT(a_elem_nonzero, out_valid && !out_error |-> out_element != '0)
  `PCD_ASSERT(a_no_load_busy, state_r != ST_LOAD |-> in_stall)

endmodule
